@@ sv/wbps_pkg.sv @@
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern search block.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Pattern capacity and byte counter width
  localparam int MAX_PATTERN_BYTES = 16;
  localparam int OFFSET_BITS       = 32;
  localparam int WIN_DEPTH         = MAX_PATTERN_BYTES - 1;

  // Register layout: the pattern registers always hold sixteen bytes
  localparam int PAT_BYTES   = 16;
  localparam int PAT_IDX_W   = 4;
  localparam int LEN_W       = 5;
  localparam int CARE_W      = 16;
  localparam int ADDR_W      = 48;
  localparam int MATCH_OFF_W = 32;
  localparam int REG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = MATCH_OFF_W + ADDR_W;

  typedef logic [7:0]              byte_t;
  typedef byte_t [PAT_BYTES-1:0]   pat_arr_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_CARE_MASK      = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_RANGE_BASE     = 3'd4
  } cfg_reg_t;

  // Per-beat control sent to every window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

@@ sv/wbps_cell.sv @@
// ----------------------------------------------------------------------------
// wbps_cell
// One window cell: holds one earlier byte, passes it on to the next cell on
// each beat and checks it against the pattern byte that lines up with it.
// ----------------------------------------------------------------------------
module wbps_cell
  import wbps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctrl_t           ctrl,
  input  logic [LEN_W-1:0]     cell_idx,        // distance of this cell, 0 = newest
  input  byte_t                byte_in,
  input  pat_arr_t             pattern,
  input  logic [CARE_W-1:0]    care_mask,
  input  logic [LEN_W-1:0]     pattern_length,
  output byte_t                byte_out,
  output logic                 cell_ok
);

  byte_t             data_r;
  byte_t             data_nxt;
  logic [LEN_W:0]    need_len;
  logic [LEN_W:0]    pat_diff;
  logic [PAT_IDX_W-1:0] pat_idx;
  logic              active;

  // Shift in from the neighbor, clear at range end
  always_comb begin
    data_nxt = data_r;
    if (ctrl.clear) begin
      data_nxt = '0;
    end else if (ctrl.shift) begin
      data_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  // This cell lines up with pattern byte length-2-idx when idx+2 <= length
  assign need_len = {1'b0, cell_idx} + (LEN_W+1)'(2);
  assign active   = need_len <= {1'b0, pattern_length};
  assign pat_diff = {1'b0, pattern_length} - need_len;
  assign pat_idx  = pat_diff[PAT_IDX_W-1:0];

  assign cell_ok  = !active || !care_mask[pat_idx] || (data_r == pattern[pat_idx]);
  assign byte_out = data_r;

endmodule

@@ sv/wildcard_byte_pattern_search_top.sv @@
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_top
// Wildcard byte signature scanner over one streamed memory range.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle unless a held result stalls it;
// each byte is checked in the cycle it is accepted against a row of window
// cells that hold the previous fifteen bytes; a stalled output holds input.
// A result (found with offset and address, or not found at the range's last
// byte) is registered in the result stage after the window compare and then
// in the output register after the base address add.
// At most one result is produced per range. Configuration writes take effect
// at once and must be made while no result is pending.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_top
  import wbps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Byte stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,     // [7:0] data_byte
  input  logic                   in_tlast,     // last_byte
  // Results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,    // [31:0] match_offset, [79:32] match_address
  output logic                   out_tuser,    // found
  // Configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);

  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

  // Configuration registers
  logic [REG_W-1:0]    pat_low_r;
  logic [REG_W-1:0]    pat_high_r;
  logic [CARE_W-1:0]   care_r;
  logic [LEN_W-1:0]    len_r;
  logic [ADDR_W-1:0]   base_r;

  // Scan state
  logic [OFFSET_BITS-1:0] bytes_seen_r, bytes_seen_nxt;
  logic                   reported_r, reported_nxt;

  // Result stage and output register
  logic                   s1_valid_r, s1_valid_nxt;
  logic                   s1_found_r;
  logic [OFFSET_BITS-1:0] s1_offset_r;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r;
  logic [MATCH_OFF_W-1:0] out_offset_r;
  logic [ADDR_W-1:0]      out_addr_r;

  pat_arr_t               pattern;
  cell_ctrl_t             ctrl;
  byte_t                  in_byte;
  byte_t                  chain [WIN_DEPTH];
  logic [MAX_PATTERN_BYTES-1:0] cell_ok;
  logic [LEN_W-1:0]       len_m1;
  logic [PAT_IDX_W-1:0]   head_idx;
  logic                   len_ok;
  logic                   pos_ok;
  logic                   hit;
  logic                   res_v;
  logic [OFFSET_BITS-1:0] hit_offset;
  logic                   in_acc;
  logic                   out_free;
  logic                   s1_move;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      care_r     <= '0;
      len_r      <= '0;
      base_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    pat_low_r  <= cfg_data;
        REG_PATTERN_HIGH:   pat_high_r <= cfg_data;
        REG_CARE_MASK:      care_r     <= cfg_data[CARE_W-1:0];
        REG_PATTERN_LENGTH: len_r      <= cfg_data[LEN_W-1:0];
        REG_RANGE_BASE:     base_r     <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack pattern bytes
  always_comb begin
    for (int j = 0; j < PAT_BYTES; j++) begin
      if (j < 8) begin
        pattern[j] = pat_low_r[8*j +: 8];
      end else begin
        pattern[j] = pat_high_r[8*(j-8) +: 8];
      end
    end
  end

  // Handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign in_byte   = in_tdata[7:0];

  assign ctrl.shift = in_acc;
  assign ctrl.clear = in_acc && in_tlast;

  // Row of window cells, newest byte in cell 0
  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    wbps_cell u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctrl           (ctrl),
      .cell_idx       (LEN_W'(k)),
      .byte_in        ((k == 0) ? in_byte : chain[(k == 0) ? 0 : k-1]),
      .pattern        (pattern),
      .care_mask      (care_r),
      .pattern_length (len_r),
      .byte_out       (chain[k]),
      .cell_ok        (cell_ok[k])
    );
  end

  // Compare the incoming byte with the final pattern byte
  assign len_m1   = len_r - LEN_W'(1);
  assign head_idx = len_m1[PAT_IDX_W-1:0];
  assign cell_ok[WIN_DEPTH] = !care_r[head_idx] || (in_byte == pattern[head_idx]);

  // Match decision for the accepted beat
  assign len_ok = (len_r != '0) && (len_r <= LEN_W'(MAX_PATTERN_BYTES));
  assign pos_ok = (bytes_seen_r != COUNT_MAX) &&
                  (bytes_seen_r >= OFFSET_BITS'(len_m1));
  assign hit    = !reported_r && len_ok && pos_ok && (&cell_ok);
  assign hit_offset = bytes_seen_r - OFFSET_BITS'(len_m1);
  assign res_v  = hit || (in_tlast && !reported_r);

  // Advance counter and report flag; clear at range end
  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    reported_nxt   = reported_r;
    if (in_acc) begin
      if (bytes_seen_r != COUNT_MAX) begin
        bytes_seen_nxt = bytes_seen_r + OFFSET_BITS'(1);
      end
      if (hit) begin
        reported_nxt = 1'b1;
      end
      if (in_tlast) begin
        bytes_seen_nxt = '0;
        reported_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      reported_r   <= 1'b0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      reported_r   <= reported_nxt;
    end
  end

  // Result stage: hold until the output register frees up
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = res_v;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_found_r  <= hit;
      s1_offset_r <= hit ? hit_offset : '0;
    end
  end

  // Output register: add the range base
  assign out_valid_nxt = s1_move ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_found_r  <= s1_found_r;
      out_offset_r <= MATCH_OFF_W'(s1_offset_r);
      out_addr_r   <= s1_found_r ? (base_r + ADDR_W'(s1_offset_r)) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {out_addr_r, out_offset_r};

  // Checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |-> !in_tready)
    else $error("input taken while result stage is blocked");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> (bytes_seen_r == '0) && !reported_r)
    else $error("scan state not cleared after last byte");

  a_reported_counts: assert property (@(posedge clk) disable iff (!rst_n)
    reported_r |-> bytes_seen_r != '0)
    else $error("match reported with no bytes counted");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("not-found result carries nonzero payload");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wildcard byte pattern search block.
// ----------------------------------------------------------------------------
// Bytes stream into the block in ranges. A scoreboard model follows every
// accepted beat and every register write, and queues the result each range
// should produce. The checker compares each output beat with the oldest
// queued result. A few directed ranges cover the corner cases. Then random
// ranges, most of them with a planted pattern, run under three mixes of
// source idling and sink stalls.
// ----------------------------------------------------------------------------
module tb;
  import wbps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned COUNT_MAX   = (64'd1 << OFFSET_BITS) - 1;
  localparam int              CYCLE_LIMIT = 500000;
  localparam int              SHOWN_ERRS  = 10;

  typedef struct packed {
    logic                   found;
    logic [MATCH_OFF_W-1:0] offset;
    logic [ADDR_W-1:0]      address;
  } scan_result_t;

  // DUT signals; the inputs are driven from time zero
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [REG_W-1:0]      cfg_data   = '0;

  // Model copy of the registers
  logic [2*REG_W-1:0] model_pattern;
  logic [CARE_W-1:0]  model_care;
  logic [LEN_W-1:0]   model_len;
  logic [ADDR_W-1:0]  model_base;

  // Model copy of the scan state
  byte_t           recent_bytes [0:WIN_DEPTH-1];
  longint unsigned bytes_seen;
  bit              hit_reported;

  scan_result_t scan_results_due [$];
  byte_t        scan_bytes [$];

  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  int beats_sent = 0;
  int error_count = 0;
  int cycle_count = 0;

  wildcard_byte_pattern_search_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sink backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Clear the per-range state
  function automatic void clear_scan_state();
    for (int k = 0; k < WIN_DEPTH; k++) recent_bytes[k] = '0;
    bytes_seen   = 0;
    hit_reported = 1'b0;
  endfunction

  // Predict the result, if any, caused by one accepted byte
  function automatic void predict_scan(input byte_t b, input logic last);
    int unsigned     len;
    bit              hit;
    byte_t           seen;
    longint unsigned offset;
    scan_result_t    res;
    len    = model_len;
    hit    = 1'b0;
    offset = 0;
    if (!hit_reported && len >= 1 && len <= MAX_PATTERN_BYTES &&
        bytes_seen < COUNT_MAX && bytes_seen >= len - 1) begin
      hit = 1'b1;
      for (int j = 0; j < len; j++) begin
        if (model_care[j]) begin
          seen = (j == len - 1) ? b : recent_bytes[len - 2 - j];
          if (seen != model_pattern[8*j +: 8]) hit = 1'b0;
        end
      end
      offset = bytes_seen - (len - 1);
    end
    // Shift the window and advance the saturating count
    for (int k = WIN_DEPTH - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
    recent_bytes[0] = b;
    if (bytes_seen < COUNT_MAX) bytes_seen++;
    if (hit) begin
      hit_reported = 1'b1;
      res.found    = 1'b1;
      res.offset   = offset[MATCH_OFF_W-1:0];
      res.address  = model_base + offset[ADDR_W-1:0];
      scan_results_due.insert(scan_results_due.size(), res);
    end
    if (last) begin
      if (!hit_reported) scan_results_due.insert(scan_results_due.size(), scan_result_t'('0));
      clear_scan_state();
    end
  endfunction

  // Track writes and input beats, check output beats
  always @(posedge clk) begin
    scan_result_t want;
    scan_result_t got;
    if (!rst_n) begin
      model_pattern = '0;
      model_care    = '0;
      model_len     = '0;
      model_base    = '0;
      clear_scan_state();
    end else begin
      if (in_tvalid && in_tready) predict_scan(in_tdata, in_tlast);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_PATTERN_LOW:    model_pattern[REG_W-1:0]       = cfg_data;
          REG_PATTERN_HIGH:   model_pattern[2*REG_W-1:REG_W] = cfg_data;
          REG_CARE_MASK:      model_care = cfg_data[CARE_W-1:0];
          REG_PATTERN_LENGTH: model_len  = cfg_data[LEN_W-1:0];
          REG_RANGE_BASE:     model_base = cfg_data[ADDR_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.found   = out_tuser;
        got.offset  = out_tdata[MATCH_OFF_W-1:0];
        got.address = out_tdata[OUT_DATA_W-1:MATCH_OFF_W];
        if (scan_results_due.size() == 0) begin
          error_count++;
          if (error_count <= SHOWN_ERRS)
            $display("ERROR: unexpected result found=%0b offset=%h address=%h",
                     got.found, got.offset, got.address);
        end else begin
          want = scan_results_due.pop_front();
          if (got.found !== want.found || got.offset !== want.offset ||
              got.address !== want.address) begin
            error_count++;
            if (error_count <= SHOWN_ERRS)
              $display("ERROR: result exp found=%0b offset=%h address=%h, got found=%0b offset=%h address=%h",
                       want.found, want.offset, want.address,
                       got.found, got.offset, got.address);
          end
        end
      end
    end
  end

  // Send one byte, with random idle cycles ahead of it
  task automatic send_byte(input byte_t b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // Send scan_bytes as one range
  task automatic send_range();
    for (int i = 0; i < scan_bytes.size(); i++)
      send_byte(scan_bytes[i], i == scan_bytes.size() - 1);
  endtask

  // Drop valid, drain results, then let the pipeline settle
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (scan_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [REG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_pattern(input logic [2*REG_W-1:0] pattern,
                              input logic [CARE_W-1:0] care,
                              input logic [LEN_W-1:0] len,
                              input logic [ADDR_W-1:0] base);
    write_reg(REG_PATTERN_LOW,    pattern[REG_W-1:0]);
    write_reg(REG_PATTERN_HIGH,   pattern[2*REG_W-1:REG_W]);
    write_reg(REG_CARE_MASK,      REG_W'(care));
    write_reg(REG_PATTERN_LENGTH, REG_W'(len));
    write_reg(REG_RANGE_BASE,     REG_W'(base));
    cfg_we <= 1'b0;
  endtask

  // Registers at reset: zero length never matches
  task automatic test_reset_defaults();
    scan_bytes = '{8'h00, 8'hFF};
    send_range();
    wait_quiet();
  endtask

  // One-byte pattern matched on a one-byte range
  task automatic test_single_byte_range();
    load_pattern(128'hFF, 16'h0001, 5'd1, 48'd0);
    scan_bytes = '{8'hFF};
    send_range();
    wait_quiet();
  endtask

  // Full 16-byte pattern ending on the last byte; address wraps to zero
  task automatic test_full_pattern_wrap();
    logic [2*REG_W-1:0] pat;
    pat = 128'h00FF_A55A_0102_0408_1020_4080_FE7F_FF00;
    load_pattern(pat, 16'hFFFF, 5'd16, 48'hFFFF_FFFF_FFFF);
    scan_bytes = '{8'h33};
    for (int j = 0; j < MAX_PATTERN_BYTES; j++)
      scan_bytes.insert(scan_bytes.size(), pat[8*j +: 8]);
    send_range();
    wait_quiet();
  endtask

  // Range shorter than an all-wildcard pattern
  task automatic test_short_range();
    load_pattern('0, 16'h0000, 5'd3, 48'h1234);
    scan_bytes = '{8'h11, 8'h22};
    send_range();
    wait_quiet();
  endtask

  // Lengths above the pattern capacity never match
  task automatic test_oversize_length();
    load_pattern('0, 16'h0000, 5'd31, 48'd7);
    scan_bytes = '{8'h12};
    send_range();
    wait_quiet();
    load_pattern('0, 16'h0000, 5'd17, 48'd7);
    scan_bytes = '{8'h34};
    send_range();
    wait_quiet();
  endtask

  // Bytes after a match give no further result, the last one included
  task automatic test_after_match();
    load_pattern('1, 16'h0000, 5'd2, 48'h1000);
    scan_bytes = '{8'h80, 8'h01, 8'h7E};
    send_range();
    wait_quiet();
  endtask

  function automatic byte_t pick_byte(input bit narrow);
    byte_t sym [3] = '{8'h00, 8'hFF, 8'h5A};
    return narrow ? sym[$urandom_range(2)] : byte_t'($urandom_range(255));
  endfunction

  // Random ranges, mostly with a planted pattern and random content
  task automatic test_random_scan(input int n_beats, input int idle_pct, input int stall_pct);
    logic [2*REG_W-1:0] pat;
    logic [CARE_W-1:0]  care;
    logic [LEN_W-1:0]   len;
    logic [ADDR_W-1:0]  base;
    bit                 narrow;
    int                 stop_at;
    int                 rlen;
    int                 pos;
    int                 r;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    stop_at = beats_sent + n_beats;
    pat = '0;
    care = '0;
    len = '0;
    narrow = 1'b0;
    while (beats_sent < stop_at) begin
      // Reprogram most of the time; otherwise ranges run back to back
      if ($urandom_range(99) < 70) begin
        wait_quiet();
        narrow = $urandom_range(1);
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) pat[8*j +: 8] = pick_byte(narrow);
        r = $urandom_range(99);
        if (r < 8)       len = 5'd0;
        else if (r < 16) len = LEN_W'($urandom_range(17, 31));
        else             len = LEN_W'($urandom_range(1, MAX_PATTERN_BYTES));
        r = $urandom_range(99);
        if (r < 15)      care = '1;
        else if (r < 22) care = '0;
        else             care = CARE_W'($urandom_range(0, 65535));
        r = $urandom_range(99);
        if (r < 10)      base = '0;
        else if (r < 20) base = '1 - ADDR_W'($urandom_range(0, 40));
        else             base = ADDR_W'({$urandom, $urandom});
        load_pattern(pat, care, len, base);
      end
      // Build the range
      r = $urandom_range(99);
      if (r < 10)      rlen = (len > 1 && len <= MAX_PATTERN_BYTES) ? $urandom_range(1, len - 1) : 1;
      else if (r < 90) rlen = $urandom_range(1, 40);
      else             rlen = $urandom_range(41, 150);
      scan_bytes = {};
      for (int i = 0; i < rlen; i++) scan_bytes.insert(scan_bytes.size(), pick_byte(narrow));
      if (len >= 1 && len <= MAX_PATTERN_BYTES && rlen >= len && $urandom_range(99) < 70) begin
        pos = $urandom_range(rlen - len);
        for (int j = 0; j < len; j++)
          if (care[j]) scan_bytes[pos + j] = pat[8*j +: 8];
      end
      send_range();
    end
    wait_quiet();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_single_byte_range();
    test_full_pattern_wrap();
    test_short_range();
    test_oversize_length();
    test_after_match();
    test_random_scan(330, 12, 56);
    test_random_scan(330, 56, 12);
    test_random_scan(340, 0, 0);
    while (scan_results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && scan_results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
